// ===== rtl/display_init_list_interpreter_defines.svh =====
// Assertion macros for the display init list interpreter.
`ifndef DISPLAY_INIT_LIST_INTERPRETER_DEFINES_SVH
`define DISPLAY_INIT_LIST_INTERPRETER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication: checked at every clock edge out of reset.
`define DILI_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dili check failed");

// Next-cycle implication: antecedent now, consequent in the next cycle.
`define DILI_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dili next-cycle check failed");

`else

`define DILI_CHECK(label, prop)
`define DILI_CHECK_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/dili_pkg.sv =====
// Shared types and constants of the display init list interpreter.
package dili_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned CMDS_W   = 8;
  localparam int unsigned ARGS_W   = 7;

  // Delay code that selects the long-delay register
  localparam logic [BYTE_W-1:0]  LONG_CODE        = 8'd255;
  localparam logic [VALUE_W-1:0] LONG_DELAY_RESET = 16'd500;

  // Parser phase
  typedef enum logic [2:0] {
    PH_COUNT = 3'd0,
    PH_CMD   = 3'd1,
    PH_ARGC  = 3'd2,
    PH_ARG   = 3'd3,
    PH_DELAY = 3'd4
  } phase_t;

  // Result kind
  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_DELAY = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

endpackage

// ===== rtl/display_init_list_interpreter.sv =====
// Display init list interpreter: byte-stream parser of a panel init command list.
//
// Input channel (in_*): one list byte per request. A list is a command count,
// then per command: command byte, argument-count byte (bit 7 = delay byte
// follows, bits 6..0 = argument count), the arguments, the optional delay byte.
// Result channel (out_*): tuser = kind (command, data, delay, end only),
// tdata = command/data byte or delay in ms, tlast = this result ends the list.
// Count and argument-count bytes produce no request unless they end the list.
// Config port (cfg_*): cfg_wr_en writes long_delay_ms, used for delay code 255.
// Write it only while the block is idle.
//
// An accepted byte is held in the input register; its result enters the output
// register when that is free or draining. One byte per cycle while the receiver
// does not stall, set by the single input-register/output-register stage pair.
// Reset: parser returns to expecting a count, long_delay_ms is 500, both
// registers empty. When the receiver stalls, the result holds and at most one
// more byte, if the input register is empty, is taken before in_tready drops.
module display_init_list_interpreter
  import dili_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [BYTE_W-1:0]   in_tdata,   // [7:0] list_byte
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [VALUE_W-1:0]  out_tdata,  // [15:0] value
  output logic [1:0]          out_tuser,  // [1:0] kind
  output logic                out_tlast,  // list_done
  // configuration
  input  logic                cfg_wr_en,
  input  logic [VALUE_W-1:0]  cfg_wr_data
);

`include "display_init_list_interpreter_defines.svh"

  // Input register
  logic               in_valid_r;
  logic [BYTE_W-1:0]  in_byte_r;

  // Parser state
  phase_t             phase_r, phase_nxt;
  logic [CMDS_W-1:0]  cmds_r, cmds_nxt;
  logic [ARGS_W-1:0]  args_r, args_nxt;
  logic               dly_pend_r, dly_pend_nxt;
  logic [VALUE_W-1:0] long_delay_r;

  // Result register
  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_done_r;

  // Combinational result of the current byte
  logic               res_valid;
  kind_t              res_kind;
  logic [VALUE_W-1:0] res_value;
  logic               res_done;

  logic               advance;
  logic [CMDS_W-1:0]  cmds_dec;
  logic               last_cmd;
  logic [ARGS_W-1:0]  args_dec;

  // Stage handshake
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  assign cmds_dec  = cmds_r - CMDS_W'(1);
  assign last_cmd  = (cmds_dec == '0);
  assign args_dec  = args_r - ARGS_W'(1);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  // Long-delay register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_delay_r <= LONG_DELAY_RESET;
    end else if (cfg_wr_en) begin
      long_delay_r <= cfg_wr_data;
    end
  end

  // Parser state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_COUNT;
      cmds_r     <= '0;
      args_r     <= '0;
      dly_pend_r <= 1'b0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      cmds_r     <= cmds_nxt;
      args_r     <= args_nxt;
      dly_pend_r <= dly_pend_nxt;
    end
  end

  // Next state and result for one list byte
  always_comb begin
    phase_nxt    = phase_r;
    cmds_nxt     = cmds_r;
    args_nxt     = args_r;
    dly_pend_nxt = dly_pend_r;
    res_valid    = 1'b0;
    res_kind     = KIND_END;
    res_value    = '0;
    res_done     = 1'b0;
    unique case (phase_r)
      PH_CMD: begin
        res_valid = 1'b1;
        res_kind  = KIND_CMD;
        res_value = {{(VALUE_W-BYTE_W){1'b0}}, in_byte_r};
        phase_nxt = PH_ARGC;
      end
      PH_ARGC: begin
        args_nxt     = in_byte_r[ARGS_W-1:0];
        dly_pend_nxt = in_byte_r[BYTE_W-1];
        if (in_byte_r[ARGS_W-1:0] != '0) begin
          phase_nxt = PH_ARG;
        end else if (in_byte_r[BYTE_W-1]) begin
          phase_nxt = PH_DELAY;
        end else begin
          // command with nothing after it
          cmds_nxt = cmds_dec;
          if (last_cmd) begin
            phase_nxt = PH_COUNT;
            res_valid = 1'b1;
            res_kind  = KIND_END;
            res_done  = 1'b1;
          end else begin
            phase_nxt = PH_CMD;
          end
        end
      end
      PH_ARG: begin
        args_nxt  = args_dec;
        res_valid = 1'b1;
        res_kind  = KIND_DATA;
        res_value = {{(VALUE_W-BYTE_W){1'b0}}, in_byte_r};
        if (args_dec == '0) begin
          if (dly_pend_r) begin
            phase_nxt = PH_DELAY;
          end else begin
            cmds_nxt  = cmds_dec;
            res_done  = last_cmd;
            phase_nxt = last_cmd ? PH_COUNT : PH_CMD;
          end
        end
      end
      PH_DELAY: begin
        dly_pend_nxt = 1'b0;
        cmds_nxt     = cmds_dec;
        res_valid    = 1'b1;
        res_kind     = KIND_DELAY;
        res_value    = (in_byte_r == LONG_CODE) ? long_delay_r
                                                : {{(VALUE_W-BYTE_W){1'b0}}, in_byte_r};
        res_done     = last_cmd;
        phase_nxt    = last_cmd ? PH_COUNT : PH_CMD;
      end
      default: begin
        // command count
        args_nxt     = '0;
        dly_pend_nxt = 1'b0;
        cmds_nxt     = in_byte_r;
        if (in_byte_r == '0) begin
          phase_nxt = PH_COUNT;
          res_valid = 1'b1;
          res_kind  = KIND_END;
          res_done  = 1'b1;
        end else begin
          phase_nxt = PH_CMD;
        end
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && res_valid) begin
      out_kind_r  <= res_kind;
      out_value_r <= res_value;
      out_done_r  <= res_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_done_r;

  // Checks
  `DILI_CHECK(a_end_is_done, out_valid_r && out_kind_r == KIND_END |-> out_done_r)
  `DILI_CHECK_NEXT(a_done_to_count, advance && res_valid && res_done, phase_r == PH_COUNT)
  `DILI_CHECK(a_cmds_live, phase_r != PH_COUNT |-> cmds_r != '0)
  `DILI_CHECK(a_args_live, phase_r == PH_ARG |-> args_r != '0)
  `DILI_CHECK(a_delay_pending, phase_r == PH_DELAY |-> dly_pend_r)

endmodule

// ===== tb/display_init_list_interpreter_tb.sv =====
// Testbench of the display init list interpreter: directed and random init lists, self-checked.
module display_init_list_interpreter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dili_pkg::*;

  localparam int RANDOM_BYTES  = 1000;
  localparam int RANDOM_PHASES = 5;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;

  // one expected result of the interpreter
  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               done;
  } panel_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [BYTE_W-1:0]   in_tdata;   // [7:0] list_byte
  logic                out_tvalid;
  logic                out_tready;
  logic [VALUE_W-1:0]  out_tdata;  // [15:0] value
  logic [1:0]          out_tuser;  // [1:0] kind
  logic                out_tlast;  // list_done
  logic                cfg_wr_en;
  logic [VALUE_W-1:0]  cfg_wr_data;

  display_init_list_interpreter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // parser copy kept by the testbench
  phase_t             parse_phase;
  logic [CMDS_W-1:0]  cmds_pending;
  logic [ARGS_W-1:0]  args_pending;
  logic               delay_follows;
  logic [VALUE_W-1:0] long_delay_ms_cfg;

  panel_result_t expected_results[$];
  int            error_count;
  int            bytes_sent;
  int            idle_cycles;
  bit            in_gaps_on;
  bit            out_stalls_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    error_count++;
  endtask

  // close one command; returns 1 when that was the last command of the list
  function automatic bit close_command();
    cmds_pending = cmds_pending - CMDS_W'(1);
    if (cmds_pending == '0) begin
      parse_phase = PH_COUNT;
      return 1'b1;
    end
    parse_phase = PH_CMD;
    return 1'b0;
  endfunction

  // advance the parser by one list byte; returns 1 if a result is produced
  function automatic bit interpret_byte(input logic [BYTE_W-1:0] b, output panel_result_t r);
    logic [VALUE_W-1:0] ms;
    r = '0;
    case (parse_phase)
      PH_CMD: begin
        r = '{KIND_CMD, VALUE_W'(b), 1'b0};
        parse_phase = PH_ARGC;
        return 1'b1;
      end
      PH_ARGC: begin
        args_pending  = b[ARGS_W-1:0];
        delay_follows = b[7];
        if (args_pending != '0) begin
          parse_phase = PH_ARG;
          return 1'b0;
        end
        if (delay_follows) begin
          parse_phase = PH_DELAY;
          return 1'b0;
        end
        if (close_command()) begin
          r = '{KIND_END, '0, 1'b1};
          return 1'b1;
        end
        return 1'b0;
      end
      PH_ARG: begin
        args_pending = args_pending - ARGS_W'(1);
        r = '{KIND_DATA, VALUE_W'(b), 1'b0};
        if (args_pending == '0) begin
          if (delay_follows) parse_phase = PH_DELAY;
          else r.done = close_command();
        end
        return 1'b1;
      end
      PH_DELAY: begin
        ms = (b == LONG_CODE) ? long_delay_ms_cfg : VALUE_W'(b);
        delay_follows = 1'b0;
        r = '{KIND_DELAY, ms, 1'b0};
        r.done = close_command();
        return 1'b1;
      end
      default: begin
        args_pending  = '0;
        delay_follows = 1'b0;
        cmds_pending  = b;
        if (b == '0) begin
          parse_phase = PH_COUNT;
          r = '{KIND_END, '0, 1'b1};
          return 1'b1;
        end
        parse_phase = PH_CMD;
        return 1'b0;
      end
    endcase
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(12, 40);
  endfunction

  // send one list byte as a request and record what it should produce
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    panel_result_t r;
    int gap;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= BYTE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    if (interpret_byte(b, r)) expected_results.push_back(r);
    bytes_sent++;
  endtask

  // stop sending and let every pending result come out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_long_delay(input logic [VALUE_W-1:0] ms);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ms;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    long_delay_ms_cfg = ms;
  endtask

  // well-formed list with random content, mostly short commands
  function automatic void build_list(ref logic [BYTE_W-1:0] lst[$]);
    int n_cmds;
    int n_args;
    int r;
    logic delay_on;
    n_cmds = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
    lst.push_back(BYTE_W'(n_cmds));
    for (int c = 0; c < n_cmds; c++) begin
      lst.push_back(BYTE_W'($urandom));
      r = $urandom_range(0, 99);
      n_args = (r == 0) ? 127 : (r < 35) ? 0 : $urandom_range(1, 4);
      delay_on = $urandom_range(0, 1);
      lst.push_back({delay_on, 7'(n_args)});
      for (int a = 0; a < n_args; a++) lst.push_back(BYTE_W'($urandom));
      if (delay_on) begin
        r = $urandom_range(0, 7);
        lst.push_back((r < 2) ? LONG_CODE : (r == 2) ? 8'd0 : BYTE_W'($urandom));
      end
    end
  endfunction

  // finish whatever list the parser is in with short commands
  task automatic close_list();
    while (parse_phase != PH_COUNT) begin
      case (parse_phase)
        PH_ARGC: send_byte({1'($urandom), 7'd0});
        default: send_byte(BYTE_W'($urandom));
      endcase
    end
  endtask

  task automatic send_random_list(input bit noisy);
    logic [BYTE_W-1:0] lst[$];
    int cut;
    build_list(lst);
    cut = noisy ? $urandom_range(1, lst.size()) : lst.size();
    for (int i = 0; i < cut; i++) send_byte(lst[i]);
    if (noisy) begin
      repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom));
      close_list();
    end
  endtask

  task automatic test_zero_count();
    send_byte(8'h00);
    drain();
  endtask

  // commands with neither arguments nor delay; the last one ends the list
  task automatic test_bare_commands();
    send_byte(8'd2);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    drain();
  endtask

  task automatic test_args_and_delays();
    // two args then a zero delay
    send_byte(8'd1);
    send_byte(8'h3A);
    send_byte(8'h82);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    // delay-only command with the long code, then one arg ending the list
    send_byte(8'd2);
    send_byte(8'h11);
    send_byte(8'h80);
    send_byte(LONG_CODE);
    send_byte(8'h29);
    send_byte(8'h01);
    send_byte(8'hAA);
    drain();
  endtask

  task automatic test_long_delay_register();
    logic [VALUE_W-1:0] settings[3];
    settings = '{16'd0, 16'hFFFF, VALUE_W'($urandom)};
    foreach (settings[i]) begin
      write_long_delay(settings[i]);
      send_byte(8'd1);
      send_byte(8'h01);
      send_byte(8'h80);
      send_byte(LONG_CODE);
      drain();
    end
    write_long_delay(LONG_DELAY_RESET);
  endtask

  // largest command count, each command bare
  task automatic test_max_count();
    send_byte(8'd255);
    repeat (255) begin
      send_byte(BYTE_W'($urandom));
      send_byte(8'h00);
    end
    drain();
  endtask

  // random lists in phases with different delay settings and idling
  task automatic test_random_lists();
    logic [VALUE_W-1:0] delay_setting;
    int target;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: delay_setting = 16'd0;
        1: delay_setting = 16'hFFFF;
        2: delay_setting = 16'd1;
        default: delay_setting = VALUE_W'($urandom);
      endcase
      write_long_delay(delay_setting);
      in_gaps_on    = (p != 1) && (p != 3);
      out_stalls_on = (p != 1) && (p != 2);
      target = bytes_sent + RANDOM_BYTES / RANDOM_PHASES;
      while (bytes_sent < target) send_random_list($urandom_range(0, 99) < 15);
      drain();
    end
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  // receiver: ready in bursts, stalls of random length
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_stalls_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
          @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    panel_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d value=%0d done=%0b",
                                  out_tuser, out_tdata, out_tlast));
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tuser !== exp_r.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_tuser, exp_r.kind));
        if (out_tdata !== exp_r.value)
          report_mismatch($sformatf("value %0d, expected %0d", out_tdata, exp_r.value));
        if (out_tlast !== exp_r.done)
          report_mismatch($sformatf("list_done %0b, expected %0b", out_tlast, exp_r.done));
      end
    end
  end

  // watchdog on cycles with no request accepted on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request accepted for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    error_count   = 0;
    bytes_sent    = 0;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    parse_phase       = PH_COUNT;
    cmds_pending      = '0;
    args_pending      = '0;
    delay_follows     = 1'b0;
    long_delay_ms_cfg = LONG_DELAY_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_count();
    test_bare_commands();
    test_args_and_delays();
    test_long_delay_register();
    test_max_count();
    test_random_lists();
    drain();

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
